>>> src/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types, constants and helpers for the PID controller with anti-windup.
// ----------------------------------------------------------------------------
package pidaw_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int DT_W      = 16;
	localparam int ERR_SHIFT = 16;
	localparam int DIV_W     = DW + DT_W;
	localparam int CNT_W     = $clog2(DIV_W);
	localparam int IDX_W     = 3;
	localparam int WIDE_W    = 68;

	localparam logic [63:0] IBOUND_WIDE = 64'd1000 << FRAC_BITS;
	localparam logic [30:0] IBOUND_RST  =
		(IBOUND_WIDE > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : IBOUND_WIDE[30:0];
	localparam logic [63:0] OUTB_WIDE   = 64'd100 << FRAC_BITS;
	localparam logic signed [31:0] OUT_HIGH_RST = OUTB_WIDE[31:0];
	localparam logic signed [31:0] OUT_LOW_RST  = -OUTB_WIDE[31:0];

	localparam logic signed [WIDE_W-1:0] MAX_W = WIDE_W'(64'sd2147483647);
	localparam logic signed [WIDE_W-1:0] MIN_W = -WIDE_W'(64'sd2147483648);

	typedef enum logic [IDX_W-1:0] {
		CFG_GAIN_P     = 3'd0,
		CFG_GAIN_I     = 3'd1,
		CFG_GAIN_D     = 3'd2,
		CFG_IBOUND     = 3'd3,
		CFG_OUT_LOW    = 3'd4,
		CFG_OUT_HIGH   = 3'd5,
		CFG_DERIV_MODE = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_ERR, OP_MULP, OP_MULE, OP_ACC, OP_MULI,
		OP_DIVINIT, OP_DIVSTEP, OP_SLOPE, OP_MULD, OP_DTERM, OP_SUM,
		OP_CLEAR, OP_INVALID
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic is_clear;
		logic dt_zero;
		logic out_free;
	} status_t;

	function automatic logic signed [DW-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [DW-1:0] r;
		if (v > MAX_W)
			r = MAX_W[DW-1:0];
		else if (v < MIN_W)
			r = MIN_W[DW-1:0];
		else
			r = v[DW-1:0];
		return r;
	endfunction

	function automatic logic signed [WIDE_W-1:0] ext(input logic signed [DW-1:0] v);
		return {{(WIDE_W-DW){v[DW-1]}}, v};
	endfunction

endpackage

>>> src/pidaw_ctrl.sv
// ----------------------------------------------------------------------------
// pidaw_ctrl
// Sequencer: steps the datapath through one update, clear or invalid step.
// ----------------------------------------------------------------------------
module pidaw_ctrl import pidaw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [14:0] {
		ST_IDLE  = 15'b000000000000001,
		ST_DISP  = 15'b000000000000010,
		ST_ERR   = 15'b000000000000100,
		ST_MULP  = 15'b000000000001000,
		ST_MULE  = 15'b000000000010000,
		ST_ACC   = 15'b000000000100000,
		ST_MULI  = 15'b000000001000000,
		ST_DIVI  = 15'b000000010000000,
		ST_DIV   = 15'b000000100000000,
		ST_SLOPE = 15'b000001000000000,
		ST_MULD  = 15'b000010000000000,
		ST_DTERM = 15'b000100000000000,
		ST_SUM   = 15'b001000000000000,
		ST_CLR   = 15'b010000000000000,
		ST_INV   = 15'b100000000000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				if (status.is_clear)
					state_d = ST_CLR;
				else if (status.dt_zero)
					state_d = ST_INV;
				else
					state_d = ST_ERR;
			end
			ST_ERR:   begin cmd.op = OP_ERR;     state_d = ST_MULP;  end
			ST_MULP:  begin cmd.op = OP_MULP;    state_d = ST_MULE;  end
			ST_MULE:  begin cmd.op = OP_MULE;    state_d = ST_ACC;   end
			ST_ACC:   begin cmd.op = OP_ACC;     state_d = ST_MULI;  end
			ST_MULI:  begin cmd.op = OP_MULI;    state_d = ST_DIVI;  end
			ST_DIVI:  begin cmd.op = OP_DIVINIT; state_d = ST_DIV;   end
			ST_DIV: begin
				cmd.op = OP_DIVSTEP;
				if (cnt_q == CNT_W'(DIV_W - 1))
					state_d = ST_SLOPE;
			end
			ST_SLOPE: begin cmd.op = OP_SLOPE;   state_d = ST_MULD;  end
			ST_MULD:  begin cmd.op = OP_MULD;    state_d = ST_DTERM; end
			ST_DTERM: begin cmd.op = OP_DTERM;   state_d = ST_SUM;   end
			ST_SUM: begin
				if (status.out_free) begin
					cmd.op  = OP_SUM;
					state_d = ST_IDLE;
				end
			end
			ST_CLR: begin
				if (status.out_free) begin
					cmd.op  = OP_CLEAR;
					state_d = ST_IDLE;
				end
			end
			ST_INV: begin
				if (status.out_free) begin
					cmd.op  = OP_INVALID;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

endmodule

>>> src/pidaw_dp.sv
// ----------------------------------------------------------------------------
// pidaw_dp
// Datapath: config registers, shared multiplier, bit-serial divider, state.
// ----------------------------------------------------------------------------
module pidaw_dp import pidaw_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [DW-1:0]           cfg_data,
	input  logic [79:0]             s_tdata,
	input  logic                    s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [DW-1:0]           m_tdata,
	output logic                    m_tuser,
	input  cmd_t                    cmd,
	output status_t                 status
);

	logic signed [DW-1:0] gain_p_q, gain_i_q, gain_d_q, out_low_q, out_high_q;
	logic [30:0]          ibound_q;
	logic                 dmode_q;

	logic signed [DW-1:0] sp_q, meas_q, err_q, diff_q, p_q, i_q, d_q, slope_q;
	logic signed [DW-1:0] integ_q, lerr_q, lmeas_q, od_q;
	logic [DT_W-1:0]      dt_q, rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic                 clr_q, neg_q, ov_q, oinv_q;
	logic signed [65:0]   prod_q;

	logic signed [32:0]       ma, mb;
	logic signed [WIDE_W-1:0] prod_w, prod_neg, t_w, s_w, ib_w;
	logic signed [DW-1:0]     e_sh, acc_s, sum_s;
	logic [DT_W:0]            shifted;
	logic [DT_W+1:0]          trial;
	logic [DW-1:0]            mag;

	always_comb begin
		case (cmd.op)
			OP_MULP: begin ma = {gain_p_q[DW-1], gain_p_q}; mb = {err_q[DW-1], err_q};   end
			OP_MULE: begin ma = {err_q[DW-1], err_q};       mb = {17'b0, dt_q};          end
			OP_MULI: begin ma = {gain_i_q[DW-1], gain_i_q}; mb = {integ_q[DW-1], integ_q}; end
			default: begin ma = {gain_d_q[DW-1], gain_d_q}; mb = {slope_q[DW-1], slope_q}; end
		endcase
	end

	always_comb begin
		prod_w   = {{(WIDE_W-66){prod_q[65]}}, prod_q};
		prod_neg = -prod_w;
		e_sh     = sat32(prod_w >>> ERR_SHIFT);
		ib_w     = WIDE_W'({1'b0, ibound_q});
		s_w      = ext(integ_q) + ext(e_sh);
		acc_s    = sat32(s_w);
		if (ext(acc_s) > ib_w)
			acc_s = ib_w[DW-1:0];
		else if (ext(acc_s) < -ib_w)
			acc_s = -ib_w[DW-1:0];
		t_w      = dmode_q ? prod_neg : prod_w;
		shifted  = {rem_q, quo_q[DIV_W-1]};
		trial    = {1'b0, shifted} - {2'b0, dt_q};
		mag      = diff_q[DW-1] ? -diff_q : diff_q;
		sum_s    = sat32(ext(p_q) + ext(i_q) + ext(d_q));
		if (sum_s > out_high_q)
			sum_s = out_high_q;
		else if (sum_s < out_low_q)
			sum_s = out_low_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q   <= '0;
			gain_i_q   <= '0;
			gain_d_q   <= '0;
			ibound_q   <= IBOUND_RST;
			out_low_q  <= OUT_LOW_RST;
			out_high_q <= OUT_HIGH_RST;
			dmode_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GAIN_P:     gain_p_q   <= cfg_data;
				CFG_GAIN_I:     gain_i_q   <= cfg_data;
				CFG_GAIN_D:     gain_d_q   <= cfg_data;
				CFG_IBOUND:     ibound_q   <= cfg_data[30:0];
				CFG_OUT_LOW:    out_low_q  <= cfg_data;
				CFG_OUT_HIGH:   out_high_q <= cfg_data;
				CFG_DERIV_MODE: dmode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			lerr_q  <= '0;
			lmeas_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (cmd.op == OP_ACC) begin
				integ_q <= acc_s;
				lerr_q  <= err_q;
				lmeas_q <= meas_q;
			end else if (cmd.op == OP_CLEAR) begin
				integ_q <= '0;
				lerr_q  <= '0;
				lmeas_q <= '0;
			end
			if (cmd.op == OP_SUM || cmd.op == OP_CLEAR || cmd.op == OP_INVALID)
				ov_q <= 1'b1;
			else if (m_tready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (cmd.op)
			OP_LOAD: begin
				sp_q   <= s_tdata[31:0];
				meas_q <= s_tdata[63:32];
				dt_q   <= s_tdata[79:64];
				clr_q  <= s_tuser;
			end
			OP_ERR:  err_q <= sat32(ext(sp_q) - ext(meas_q));
			OP_MULP: diff_q <= dmode_q ? sat32(ext(meas_q) - ext(lmeas_q))
			                           : sat32(ext(err_q) - ext(lerr_q));
			OP_MULE: p_q <= sat32(prod_w >>> FRAC_BITS);
			OP_DIVINIT: begin
				i_q   <= sat32(prod_w >>> FRAC_BITS);
				neg_q <= diff_q[DW-1];
				quo_q <= {mag, {DT_W{1'b0}}};
				rem_q <= '0;
			end
			OP_DIVSTEP: begin
				rem_q <= trial[DT_W+1] ? shifted[DT_W-1:0] : trial[DT_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], ~trial[DT_W+1]};
			end
			OP_SLOPE: slope_q <= neg_q ? sat32(-WIDE_W'(quo_q)) : sat32(WIDE_W'(quo_q));
			OP_DTERM: d_q <= sat32(t_w >>> FRAC_BITS);
			OP_SUM: begin
				od_q   <= sum_s;
				oinv_q <= 1'b0;
			end
			OP_CLEAR: begin
				od_q   <= '0;
				oinv_q <= 1'b0;
			end
			OP_INVALID: begin
				od_q   <= '0;
				oinv_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign status.is_clear = clr_q;
	assign status.dt_zero  = (dt_q == '0);
	assign status.out_free = !ov_q || m_tready;
	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;
	assign m_tuser  = oinv_q;

endmodule

>>> src/pid_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// Fixed-point PID controller with clamped integral and output limits.
// ----------------------------------------------------------------------------
// Input stream: s_tdata = {time_step, measurement, setpoint}, s_tuser = clear.
// Output stream: m_tdata = control_output, m_tuser = step_invalid.
// Exactly one output transaction per input transaction, in order.
// Config: cfg_we/cfg_index/cfg_data write one register per cycle. The user
// writes only while idle; the block does not enforce it. Index 0..6: gain_p,
// gain_i, gain_d, integral_bound, output_low, output_high, deriv_on_measurement.
// An update uses the shared 33x33 multiplier for its products and 48 steps
// of the one-bit-per-cycle divider forming the slope.
// One transaction is processed at a time; s_tready is high only when idle,
// which is the cycle after the result is written, so a new transaction is
// taken only after the previous one has written its result.
// The result sits in an output register; the next input is taken while it
// waits, but its result holds until the receiver takes the previous one.
// Reset clears the state and loads the register defaults.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup import pidaw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DW-1:0]    cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [79:0]      s_tdata,  // setpoint, measurement, time_step
	input  logic             s_tuser,  // req_type
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [DW-1:0]    m_tdata,  // control_output
	output logic             m_tuser   // step_invalid
);

	cmd_t    cmd;
	status_t status;

	pidaw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pidaw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.status    (status)
	);

`ifndef SYNTHESIS
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("invalid step with nonzero output");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a second transaction while busy");
	a_out_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.op == OP_SUM || cmd.op == OP_CLEAR
			|| cmd.op == OP_INVALID))
		else $error("output raised without a result");
`endif

endmodule
